>>> hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker
// expects signals named clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define BUBOX_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BUBOX_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/bubox_pkg.sv
// shared types and constants of the bilinear upscale and box blur block
// no dependencies
package bubox_pkg;

	localparam int CFG_W       = 9;   // widest configuration register
	localparam int CFG_IDX_W   = 1;
	localparam int COORD_W     = 9;
	localparam int PIX_IN_W    = 16;
	localparam int OUT_W       = 22;
	localparam int DIM_W       = 14;  // holds an effective dimension up to 16383
	localparam int S_TDATA_W   = 40;  // coord_x, coord_y, pixel_value, zero fill
	localparam int M_TDATA_W   = 24;  // blurred_value, zero fill

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 1'd1;

	// command codes carried in s_tuser
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [CFG_W-1:0] SRC_DIM_RESET = 9'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} bubox_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // input item accepted this cycle
		logic rd_en;     // issue one source read of the 3x3 footprint
		logic load_out;  // move the finished sum into the output register
	} bubox_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_read;   // offered item is a read
		logic hit;       // offered read lies inside the window
		logic last_tap;  // current tap is the last of the footprint
		logic out_free;  // output register can take a new item
	} bubox_status_t;

endpackage

>>> hw/rtl/bubox_ctrl.sv
// controller state machine of the bilinear upscale and box blur block
// depends on bubox_pkg
module bubox_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  bubox_pkg::bubox_status_t status,
	output bubox_pkg::bubox_cmd_t    cmd
);
	import bubox_pkg::*;

	bubox_state_t state_q;
	bubox_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && status.is_read) begin
					state_nxt = status.hit ? ST_READ : ST_EMIT;
				end
			end
			ST_READ: begin
				if (status.last_tap) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.take     = (state_q == ST_IDLE) && s_tvalid;
		cmd.rd_en    = (state_q == ST_READ);
		cmd.load_out = (state_q == ST_EMIT) && status.out_free;
	end

endmodule

>>> hw/rtl/bubox_dp.sv
// datapath: configuration registers, source store, tap counters,
// weighted accumulator and output register; depends on bubox_pkg
module bubox_dp #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bubox_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bubox_pkg::CFG_W-1:0]       cfg_data,
	input  logic [bubox_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bubox_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	input  bubox_pkg::bubox_cmd_t             cmd,
	output bubox_pkg::bubox_status_t          status
);
	import bubox_pkg::*;

	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int ACC_W = PIXEL_BITS + 6;

	// horizontal or vertical weight of footprint position idx
	function automatic logic [2:0] tap_weight(input logic odd, input logic [1:0] idx);
		logic [2:0] w;
		case (idx)
			2'd0:    w = odd ? 3'd1 : 3'd3;
			2'd1:    w = 3'd4;
			2'd2:    w = odd ? 3'd3 : 3'd1;
			default: w = 3'd0;
		endcase
		return w;
	endfunction

	logic [CFG_W-1:0]      width_q;
	logic [CFG_W-1:0]      height_q;
	logic [COORD_W-1:0]    cx;
	logic [COORD_W-1:0]    cy;
	logic [PIX_IN_W-1:0]   pix_in;
	logic [DIM_W-1:0]      w_eff;
	logic [DIM_W-1:0]      h_eff;
	logic [DIM_W:0]        lim_x;
	logic [DIM_W:0]        lim_y;
	logic                  hit;

	logic [7:0]            a_q;
	logic [7:0]            b_q;
	logic                  px_q;
	logic                  py_q;
	logic                  hit_q;
	logic [1:0]            col_q;
	logic [1:0]            row_q;

	logic [PIXEL_BITS-1:0] mem [0:DEPTH-1];
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         addr;
	logic [8:0]            xs;
	logic [8:0]            ys;

	logic [PIXEL_BITS-1:0] rd_s1;
	logic [4:0]            w_s1;
	logic                  vld_s1;
	logic [ACC_W-1:0]      prod;
	logic [ACC_W-1:0]      acc_q;

	logic                  out_vld_q;
	logic [OUT_W-1:0]      out_val_q;
	logic                  out_win_q;

	// fields of the offered item
	assign cx     = s_tdata[COORD_W-1:0];
	assign cy     = s_tdata[2*COORD_W-1:COORD_W];
	assign pix_in = s_tdata[2*COORD_W+PIX_IN_W-1:2*COORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SRC_DIM_RESET;
			height_q <= SRC_DIM_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SRC_WIDTH:  width_q  <= cfg_data;
				REG_SRC_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, large values saturate
	always_comb begin
		if (width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (DIM_W'(width_q) > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = DIM_W'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (DIM_W'(height_q) > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = DIM_W'(height_q);
		end
		lim_x = {w_eff, 1'b0} - (DIM_W+1)'(4);
		lim_y = {h_eff, 1'b0} - (DIM_W+1)'(4);
		hit   = (w_eff > DIM_W'(2)) && (h_eff > DIM_W'(2)) &&
		        ((DIM_W+1)'(cx) < lim_x) && ((DIM_W+1)'(cy) < lim_y);
	end

	// read item: keep the footprint origin and the sample phases; each read advances the tap counters
	always_ff @(posedge clk) begin
		if (cmd.take && (s_tuser == CMD_READ)) begin
			a_q   <= cx[8:1];
			b_q   <= cy[8:1];
			px_q  <= cx[0];
			py_q  <= cy[0];
			hit_q <= hit;
			col_q <= 2'd0;
			row_q <= 2'd0;
		end else if (cmd.rd_en) begin
			if (col_q == 2'd2) begin
				col_q <= 2'd0;
				row_q <= row_q + 2'd1;
			end else begin
				col_q <= col_q + 2'd1;
			end
		end
	end

	// single-port source store, rows of 2**XW entries
	assign wr_en   = cmd.take && (s_tuser == CMD_WRITE) &&
	                 (32'(cx) < MAX_WIDTH) && (32'(cy) < MAX_HEIGHT);
	assign wr_addr = {YW'(cy), XW'(cx)};
	assign xs      = 9'(a_q) + 9'(col_q);
	assign ys      = 9'(b_q) + 9'(row_q);
	assign rd_addr = {YW'(ys), XW'(xs)};
	assign addr    = cmd.rd_en ? rd_addr : wr_addr;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= PIXEL_BITS'(pix_in);
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			w_s1 <= 5'(tap_weight(px_q, col_q)) * 5'(tap_weight(py_q, row_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
		end
	end

	assign prod = ACC_W'(rd_s1) * ACC_W'(w_s1);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			acc_q <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + prod;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_val_q <= hit_q ? OUT_W'(acc_q) : '0;
			out_win_q <= hit_q;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = M_TDATA_W'(out_val_q);
	assign m_tuser  = out_win_q;

	assign status.is_read  = (s_tuser == CMD_READ);
	assign status.hit      = hit;
	assign status.last_tap = (col_q == 2'd2) && (row_q == 2'd2);
	assign status.out_free = !out_vld_q || m_tready;

endmodule

>>> hw/rtl/bilinear_upscale_box_blur_top.sv
// top level of the bilinear 2x upscale with 4x4 box filter
// depends on bubox_pkg, bubox_ctrl and bubox_dp
//
// channel   dir  handshake          payload
// s_*       in   tvalid / tready    tuser: command; tdata: coord_x, coord_y, pixel_value
// m_*       out  tvalid / tready    tuser: in_window; tdata: blurred_value
// cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// a write item gives no result and leaves the block ready for the next item
// a read item inside the window passes through acceptance, nine reads of the
// 3x3 source footprint through the single port of the source store, a drain step
// that adds the last product, and the output load
// a read item outside the window goes from acceptance straight to the output load
// and returns zero
// the output register lets the next item in while a result waits on m_tready
// reset clears control and configuration; the source store is not cleared
module bilinear_upscale_box_blur_top #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int PIXEL_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [bubox_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bubox_pkg::CFG_W-1:0]       cfg_data,
	// input items
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bubox_pkg::S_TDATA_W-1:0]   s_tdata,  // coord_x, coord_y, pixel_value
	input  logic                              s_tuser,  // command
	// result items
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bubox_pkg::M_TDATA_W-1:0]   m_tdata,  // blurred_value
	output logic                              m_tuser   // in_window
);
	import bubox_pkg::*;

	bubox_cmd_t    cmd;
	bubox_status_t status;

	// sequencing of accept, footprint reads, drain and output load
	bubox_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// store, weights, accumulator and output register
	bubox_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.PIXEL_BITS (PIXEL_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

>>> hw/rtl/bubox_chk.sv
// port-level checker for the bilinear upscale and box blur top level
// depends on bubox_pkg and assert_macros.svh; bound to the top level below
`include "assert_macros.svh"

module bubox_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              s_tuser,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [bubox_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                              m_tuser
);
	import bubox_pkg::*;

	// a result outside the window carries zero
	`BUBOX_ASSERT(a_zero_outside, m_tvalid && !m_tuser |-> m_tdata == '0, "nonzero value outside window")

	// a write item never holds up the next item
	`BUBOX_ASSERT(a_write_no_stall, s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> s_tready, "stall after write")

	// a read item drops ready straight after its acceptance
	`BUBOX_ASSERT(a_read_busy, s_tvalid && s_tready && (s_tuser == CMD_READ) |=> !s_tready, "ready straight after read")

	// a stalled result stays and holds its payload
	`BUBOX_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

	// no result is offered under reset
	`BUBOX_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind bilinear_upscale_box_blur_top bubox_chk u_bubox_chk (.*);
